// ===== rtl/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants of the multi-queue shared-buffer core.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int STAT_W = 2;

  localparam int SLOTS_DEF  = 16;
  localparam int QUEUES_DEF = 4;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              func;
    logic              q_ok;
    logic [QID_W-1:0]  qid;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mqsb_front.sv =====
// ----------------------------------------------------------------------------
// mqsb_front
// Accepts request beats, checks the queue number and holds decoded commands
// in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_front #(
  parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [mqsb_pkg::DATA_W-1:0] in_tdata,
  input  wire logic [mqsb_pkg::QID_W:0]   in_tuser,
  output mqsb_pkg::cmd_t                  cmd,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready
);
  import mqsb_pkg::*;

  localparam int AW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);

  cmd_t          ent_r [CQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  cmd_t          new_cmd;
  logic          push, pop;

  always_comb begin
    new_cmd.func = in_tuser[0];
    new_cmd.qid  = in_tuser[QID_W:1];
    new_cmd.q_ok = int'(in_tuser[QID_W:1]) < QUEUES;
    new_cmd.data = in_tdata;
  end

  assign in_tready = count_r != CW'(CQ_DEPTH);
  assign cmd_valid = count_r != '0;
  assign cmd       = ent_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mqsb_back.sv =====
// ----------------------------------------------------------------------------
// mqsb_back
// Executes queued commands against the slot store: link and data memories,
// queue head/tail pointers, free list and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_back #(
  parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
  parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mqsb_pkg::cmd_t              cmd,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [mqsb_pkg::DATA_W-1:0]      out_tdata,
  output logic [mqsb_pkg::STAT_W-1:0]      out_tuser
);
  import mqsb_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [LW-1:0] NULL_IDX = LW'(SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state_r, state_nxt;
  logic              op_deq_r, op_deq_nxt;
  logic [QW-1:0]     qidx_r, qidx_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [LW-1:0]     free_head_r, free_head_nxt;
  logic [LW-1:0]     fresh_cnt_r, fresh_cnt_nxt;
  logic [LW-1:0]     head_r [QUEUES];
  logic [LW-1:0]     tail_r [QUEUES];
  logic [LW-1:0]     head_nxt, tail_nxt;
  logic              hq_we;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [LW-1:0]     link_mem [SLOTS];
  logic [DATA_W-1:0] data_mem [SLOTS];
  logic [LW-1:0]     link_rd_r;
  logic [DATA_W-1:0] data_rd_r;

  logic              link_re, link_we, data_re, data_we;
  logic [IW-1:0]     link_ra, link_wa, data_a;
  logic [LW-1:0]     link_wd;

  logic [QW-1:0]     qsel;
  logic [LW-1:0]     cur_head, cur_tail, next_ptr;
  logic              slot_free, pop, run;
  logic [IW-1:0]     idx_a;

  assign slot_free = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;
  assign pop       = cmd_valid && cmd_ready;

  assign qsel     = (state_r == S_EXEC) ? qidx_r : QW'(cmd.qid);
  assign cur_head = head_r[qsel];
  assign cur_tail = tail_r[qsel];

  always_comb begin
    state_nxt     = state_r;
    op_deq_nxt    = op_deq_r;
    qidx_nxt      = qidx_r;
    idx_nxt       = idx_r;
    free_head_nxt = free_head_r;
    fresh_cnt_nxt = fresh_cnt_r;
    head_nxt      = cur_head;
    tail_nxt      = cur_tail;
    hq_we         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    link_re       = 1'b0;
    link_we       = 1'b0;
    data_re       = 1'b0;
    data_we       = 1'b0;
    link_ra       = '0;
    link_wa       = '0;
    link_wd       = '0;
    data_a        = '0;
    next_ptr      = link_rd_r;
    idx_a         = (cmd.func == FUNC_DEQ) ? cur_head[IW-1:0] : free_head_r[IW-1:0];
    run           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          if (cmd.func == FUNC_DEQ) begin
            run = cmd.q_ok && (cur_head != NULL_IDX);
          end else begin
            run = cmd.q_ok && (free_head_r != NULL_IDX);
          end
          if (run) begin
            link_re    = 1'b1;
            link_ra    = idx_a;
            data_a     = idx_a;
            data_we    = (cmd.func == FUNC_ENQ);
            data_re    = (cmd.func == FUNC_DEQ);
            op_deq_nxt = (cmd.func == FUNC_DEQ);
            qidx_nxt   = QW'(cmd.qid);
            idx_nxt    = idx_a;
            state_nxt  = S_EXEC;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_stat_nxt  = (cmd.func == FUNC_DEQ) ? ST_EMPTY : ST_FULL;
          end
        end
      end
      S_EXEC: begin
        hq_we         = 1'b1;
        out_valid_nxt = 1'b1;
        out_stat_nxt  = ST_OK;
        state_nxt     = S_IDLE;
        if (op_deq_r) begin
          // the tail's link is never used: a lone slot leaves the queue empty
          next_ptr      = (cur_head == cur_tail) ? NULL_IDX : link_rd_r;
          head_nxt      = next_ptr;
          tail_nxt      = (next_ptr == NULL_IDX) ? NULL_IDX : cur_tail;
          link_we       = 1'b1;
          link_wa       = idx_r;
          link_wd       = free_head_r;
          free_head_nxt = LW'(idx_r);
          out_data_nxt  = data_rd_r;
        end else begin
          // slots at or above the fill count are untouched: the next free slot is the next index
          if (LW'(idx_r) == fresh_cnt_r) begin
            free_head_nxt = LW'(idx_r) + LW'(1);
            fresh_cnt_nxt = LW'(idx_r) + LW'(1);
          end else begin
            free_head_nxt = link_rd_r;
          end
          if (cur_head == NULL_IDX) begin
            head_nxt = LW'(idx_r);
          end else begin
            link_we = 1'b1;
            link_wa = cur_tail[IW-1:0];
            link_wd = LW'(idx_r);
          end
          tail_nxt     = LW'(idx_r);
          out_data_nxt = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fresh_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= NULL_IDX;
        tail_r[i] <= NULL_IDX;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fresh_cnt_r <= fresh_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (hq_we) begin
        head_r[qidx_r] <= head_nxt;
        tail_r[qidx_r] <= tail_nxt;
      end
    end
    op_deq_r   <= op_deq_nxt;
    qidx_r     <= qidx_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_a] <= cmd.data;
    end
    if (data_re) begin
      data_rd_r <= data_mem[data_a];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

`ifndef ASSERT_OFF
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_IDLE))
    else $error("exec state held longer than one cycle");

  a_exec_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result register busy when exec completes");

  a_free_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= fresh_cnt_r) && (fresh_cnt_r <= NULL_IDX))
    else $error("free list head beyond fill count");

  a_head_tail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> ((cur_head == NULL_IDX) == (cur_tail == NULL_IDX)))
    else $error("queue head and tail disagree on empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/multi_queue_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core
// QUEUES fifo queues sharing one store of SLOTS words through linked lists.
// ----------------------------------------------------------------------------
// Each request beat enqueues a word on a queue or dequeues from it and gives
// exactly one result beat (word, status). Requests land in a two-entry command
// queue, so the input keeps accepting while the back end works or a result
// waits. A successful enqueue or dequeue reads the link memory in the idle
// state, then writes the link back and updates pointers in the exec state;
// a store-full or queue-empty result is registered from idle. No clearing
// pass is needed after reset: untouched slots are tracked by a fill count.
`default_nettype none

module multi_queue_shared_buffer_core #(
  parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
  parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [mqsb_pkg::DATA_W-1:0]  in_tdata,   // data_in
  input  wire logic [mqsb_pkg::QID_W:0]     in_tuser,   // func, queue_id
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [mqsb_pkg::DATA_W-1:0]       out_tdata,  // data_out
  output logic [mqsb_pkg::STAT_W-1:0]       out_tuser   // status
);
  import mqsb_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  mqsb_front #(
    .QUEUES (QUEUES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  mqsb_back #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== bench/tb_multi_queue_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer_core
// Self-checking bench for the linked-list multi-queue core.
// Request beats are scored against a behavioral model of the slot store, its
// free list and per-queue lists. The run covers directed corners, a long
// output hold-off and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_queue_shared_buffer_core;
  import mqsb_pkg::*;

  localparam int SLOTS   = SLOTS_DEF;
  localparam int QUEUES  = QUEUES_DEF;
  localparam int IDX_W   = $clog2(SLOTS + 1);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(SLOTS);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
  } reply_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;   // data_in
  logic [QID_W:0]    in_tuser   = '0;   // func, queue_id
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;         // data_out
  logic [STAT_W-1:0] out_tuser;         // status

  // shadow of the slot store
  logic [DATA_W-1:0] slot_word  [SLOTS];
  logic [IDX_W-1:0]  slot_next  [SLOTS];
  logic [IDX_W-1:0]  q_first    [QUEUES];
  logic [IDX_W-1:0]  q_last     [QUEUES];
  logic [IDX_W-1:0]  free_first;

  reply_t replies_due[$];
  int     err_count          = 0;
  int     sender_idle_pct    = 0;
  int     receiver_stall_pct = 0;
  int     hold_request       = 0;
  int     hold_left          = 0;

  multi_queue_shared_buffer_core #(
    .SLOTS (SLOTS),
    .QUEUES(QUEUES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void clear_store_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      slot_next[i] = IDX_W'(i + 1);
    end
    slot_next[SLOTS-1] = NIL;
    for (int q = 0; q < QUEUES; q++) begin
      q_first[q] = NIL;
      q_last[q]  = NIL;
    end
    free_first = '0;
  endfunction

  function automatic reply_t predict_reply(logic func, logic [QID_W-1:0] qid,
                                           logic [DATA_W-1:0] word);
    reply_t           r;
    logic [IDX_W-1:0] idx;
    r.data = '0;
    if (int'(qid) >= QUEUES) begin
      r.status = (func == FUNC_ENQ) ? ST_FULL : ST_EMPTY;
    end else if (func == FUNC_ENQ) begin
      idx = free_first;
      if (idx >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        free_first = (slot_next[idx[SLOT_AW-1:0]] < SLOTS) ?
                     slot_next[idx[SLOT_AW-1:0]] : NIL;
        slot_word[idx[SLOT_AW-1:0]] = word;
        slot_next[idx[SLOT_AW-1:0]] = NIL;
        if (q_first[qid] >= SLOTS || q_last[qid] >= SLOTS) begin
          q_first[qid] = idx;
        end else begin
          slot_next[q_last[qid][SLOT_AW-1:0]] = idx;
        end
        q_last[qid] = idx;
        r.status = ST_OK;
      end
    end else begin
      idx = q_first[qid];
      if (idx >= SLOTS) begin
        r.status = ST_EMPTY;
      end else begin
        q_first[qid] = (slot_next[idx[SLOT_AW-1:0]] < SLOTS) ?
                       slot_next[idx[SLOT_AW-1:0]] : NIL;
        // last slot gone: queue is empty again
        if (q_first[qid] >= SLOTS) q_last[qid] = NIL;
        slot_next[idx[SLOT_AW-1:0]] = free_first;
        free_first = idx;
        r.data = slot_word[idx[SLOT_AW-1:0]];
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // result side: score each beat, then pick the next ready value
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat, expected none, actual data %h status %0d",
                 $time, out_tdata, out_tuser);
      end else begin
        exp_r = replies_due.pop_front();
        if (out_tdata !== exp_r.data) begin
          err_count++;
          $display("%0t: data_out mismatch, expected %h actual %h",
                   $time, exp_r.data, out_tdata);
        end
        if (out_tuser !== exp_r.status) begin
          err_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_r.status, out_tuser);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(input logic func, input logic [QID_W-1:0] qid,
                              input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= {qid, func};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(predict_reply(func, qid, word));
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_basic_ops();
    send_request(FUNC_DEQ, 2'd3, 32'h1234_5678);   // dequeue from empty queue
    send_request(FUNC_ENQ, 2'd0, 32'h8000_0000);
    send_request(FUNC_ENQ, 2'd1, 32'h7fff_ffff);
    send_request(FUNC_ENQ, 2'd2, 32'h0000_0000);
    send_request(FUNC_ENQ, 2'd3, 32'hffff_ffff);
    send_request(FUNC_DEQ, 2'd3, 32'h0);
    send_request(FUNC_DEQ, 2'd2, 32'hffff_ffff);
    send_request(FUNC_DEQ, 2'd1, 32'h0);
    send_request(FUNC_DEQ, 2'd0, 32'h5555_aaaa);
    drain_replies();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < SLOTS; i++) begin
      send_request(FUNC_ENQ, QID_W'(i % QUEUES), (i % 2) ? 32'haaaa_5555 : 32'h5555_aaaa);
    end
    send_request(FUNC_ENQ, 2'd1, 32'hdead_beef);
    send_request(FUNC_ENQ, 2'd3, 32'h0bad_f00d);
    for (int q = 0; q < QUEUES; q++) begin
      for (int k = 0; k < SLOTS / QUEUES; k++) send_request(FUNC_DEQ, QID_W'(q), $urandom);
    end
    send_request(FUNC_DEQ, 2'd2, 32'h0);
    drain_replies();
  endtask

  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 80;
    for (int i = 0; i < 12; i++) begin
      send_request((i < 8) ? FUNC_ENQ : FUNC_DEQ, QID_W'($urandom_range(3)), pick_word());
    end
    drain_replies();
  endtask

  task automatic run_traffic(input int n, input int idle_pct, input int stall_pct);
    int enq_pct;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      // lean toward filling first, then toward draining
      enq_pct = (i < n / 2) ? 65 : 35;
      send_request(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                   QID_W'($urandom_range(3)), pick_word());
    end
    drain_replies();
  endtask

  task automatic test_random_traffic();
    run_traffic(120, 0, 0);
    run_traffic(120, 82, 0);
    run_traffic(120, 0, 82);
    run_traffic(120, 20, 20);
  endtask

  initial begin
    clear_store_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_store_full();
    test_backpressure();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mqsb_pkg.sv
rtl/mqsb_front.sv
rtl/mqsb_back.sv
rtl/multi_queue_shared_buffer_core.sv
bench/tb_multi_queue_shared_buffer_core.sv
